// ===== src/rrs_pkg.sv =====
package rrs_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned FieldW = 16;
  localparam int unsigned IdW    = 5;

  typedef struct packed {
    logic [FieldW-1:0] arrive_at;
    logic [FieldW-1:0] need_time;
    logic              last_process;
  } in_item_t;

  typedef struct packed {
    logic [IdW-1:0]   process_id;
    logic [TimeW-1:0] finish_time;
    logic [TimeW-1:0] turnaround;
    logic [TimeW-1:0] waiting;
    logic [TimeW-1:0] total_waiting;
    logic [TimeW-1:0] total_turnaround;
    logic             overflowed;
    logic             last_result;
  } out_item_t;

  // One table row: arrival, burst, remaining time and load-order id
  typedef struct packed {
    logic [FieldW-1:0] arr;
    logic [FieldW-1:0] bur;
    logic [FieldW-1:0] rem;
    logic [IdW-1:0]    id;
  } entry_t;

  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
  endfunction

endpackage

// ===== src/rrs_if.sv =====
interface rrs_in_if;
  logic               valid;
  logic               ready;
  rrs_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rrs_out_if;
  logic               valid;
  logic               ready;
  rrs_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rrs_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/round_robin_schedule_sim.sv =====
// Round-robin scheduling simulator.
// in_ch carries process records (arrival, burst, last flag); the id of a
// record is its load order. Records past the table depth are dropped and
// the run is marked overflowed. A record with last_process set starts the
// run: the table is exchange-sorted by arrival, then a round-robin
// simulation with the slice in cfg is stepped, one table entry per scan step.
// out_ch gives one completion record per process, in completion order,
// with last_result on the final one.
// Non-final records are accepted whenever the block is idle. After the final
// record the block is busy with the sort (none for a single record), then
// with the scan steps and the completions; every step goes through the single
// read port of the entry table.
// in_ch.ready is high only while no run is in progress. cfg is always ready;
// the user is to write it between runs, as the block does not enforce this.
// Reset empties the table and sets the slice to 4. If the receiver stalls,
// the finished record is held in the output register and the simulation
// waits before producing the next one.
module round_robin_schedule_sim #(
  parameter int unsigned MAX_PROCESSES = 32
) (
  input  logic      clk,
  input  logic      rst,
  rrs_cfg_if.sink   cfg,
  rrs_in_if.sink    in_ch,
  rrs_out_if.source out_ch
);
  import rrs_pkg::*;

  localparam int unsigned IW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int unsigned CW = $clog2(MAX_PROCESSES + 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_S_RDI = 4'd1;
  localparam logic [3:0] ST_S_LDI = 4'd2;
  localparam logic [3:0] ST_S_CMP = 4'd3;
  localparam logic [3:0] ST_S_WRI = 4'd4;
  localparam logic [3:0] ST_FIRST = 4'd5;
  localparam logic [3:0] ST_CHK   = 4'd6;
  localparam logic [3:0] ST_RUN   = 4'd7;
  localparam logic [3:0] ST_NEXT  = 4'd8;
  localparam logic [3:0] ST_CALC  = 4'd9;
  localparam logic [3:0] ST_WAIT  = 4'd10;
  localparam logic [3:0] ST_EMIT  = 4'd11;

  logic [3:0]         state, state_next;
  logic [FieldW-1:0]  time_slice;
  logic [CW-1:0]      loaded_count, n_total;
  logic               dropped_flag;
  logic [TimeW-1:0]   sim_time;
  logic [IW-1:0]      scan_index, si, sj;
  logic [CW-1:0]      unfinished_count;
  logic [MAX_PROCESSES-1:0] fin;
  entry_t             cur, done_e;
  logic [TimeW-1:0]   ta, wt, tot_wait, tot_turn;

  entry_t             mem [MAX_PROCESSES];
  entry_t             rdata;
  logic [IW-1:0]      raddr, waddr, first_idx;
  logic               we;
  entry_t             wdata;

  logic [FieldW-1:0]  slice_eff;
  logic               in_xfer, has_room, out_free;
  logic [CW-1:0]      scan_p1, si_p1, sj_p1;

  assign slice_eff = (time_slice == '0) ? FieldW'(1) : time_slice;
  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign has_room  = loaded_count < CW'(MAX_PROCESSES);
  assign out_free  = !out_ch.valid || out_ch.ready;
  assign scan_p1   = CW'(scan_index) + CW'(1);
  assign si_p1     = CW'(si) + CW'(1);
  assign sj_p1     = CW'(sj) + CW'(1);
  assign in_ch.ready = (state == ST_IDLE);
  assign cfg.ready   = 1'b1;

  // Pick the lowest unfinished entry, which has the earliest arrival
  always_comb begin
    first_idx = '0;
    for (int k = MAX_PROCESSES - 1; k >= 0; k--) begin
      if (!fin[k]) first_idx = IW'(k);
    end
  end

  // Table memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_comb begin
    state_next = state;
    raddr = scan_index;
    we    = 1'b0;
    waddr = scan_index;
    wdata = rdata;
    unique case (state)
      ST_IDLE: begin
        waddr = loaded_count[IW-1:0];
        wdata.arr = in_ch.data.arrive_at;
        wdata.bur = in_ch.data.need_time;
        wdata.rem = in_ch.data.need_time;
        wdata.id  = IdW'(loaded_count);
        we = in_xfer && has_room;
        if (in_xfer && in_ch.data.last_process) begin
          state_next = (n_total >= CW'(2)) ? ST_S_RDI : ST_FIRST;
        end
      end
      ST_S_RDI: begin
        raddr = si;
        state_next = ST_S_LDI;
      end
      ST_S_LDI: begin
        raddr = si_p1[IW-1:0];
        state_next = ST_S_CMP;
      end
      ST_S_CMP: begin
        waddr = sj;
        wdata = cur;
        we = rdata.arr < cur.arr;
        raddr = sj_p1[IW-1:0];
        if (sj_p1 >= loaded_count) state_next = ST_S_WRI;
      end
      ST_S_WRI: begin
        waddr = si;
        wdata = cur;
        we = 1'b1;
        state_next = (si_p1 + CW'(1) < loaded_count) ? ST_S_RDI : ST_FIRST;
      end
      ST_FIRST: begin
        raddr = first_idx;
        state_next = ST_CHK;
      end
      ST_CHK: begin
        raddr = scan_index;
        state_next = ST_RUN;
      end
      ST_RUN: begin
        raddr = scan_p1[IW-1:0];
        if (!fin[scan_index] && TimeW'(rdata.arr) <= sim_time) begin
          if (rdata.rem <= slice_eff) begin
            state_next = ST_CALC;
          end else begin
            wdata.rem = rdata.rem - slice_eff;
            we = 1'b1;
            state_next = (scan_p1 >= loaded_count) ? ST_FIRST : ST_NEXT;
          end
        end else begin
          state_next = (scan_p1 >= loaded_count) ? ST_FIRST : ST_NEXT;
        end
      end
      ST_NEXT: begin
        state_next = ST_FIRST;
      end
      ST_CALC: state_next = ST_WAIT;
      ST_WAIT: state_next = ST_EMIT;
      ST_EMIT: begin
        raddr = scan_p1[IW-1:0];
        if (out_free) begin
          if (unfinished_count == '0) state_next = ST_IDLE;
          else if (scan_p1 >= loaded_count) state_next = ST_FIRST;
          else state_next = ST_NEXT;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Table size for the run, counting a record accepted in this cycle
  assign n_total = loaded_count + CW'(has_room);

  // Control state and run bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      time_slice       <= FieldW'(4);
      loaded_count     <= '0;
      dropped_flag     <= 1'b0;
      sim_time         <= '0;
      scan_index       <= '0;
      unfinished_count <= '0;
      out_ch.valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) time_slice <= cfg.data;
      // Raise valid on a new record, drop it once the transfer completes
      if (state == ST_EMIT && out_free) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            if (has_room) loaded_count <= loaded_count + CW'(1);
            else dropped_flag <= 1'b1;
            if (in_ch.data.last_process) begin
              unfinished_count <= n_total;
              sim_time   <= '0;
              scan_index <= '0;
            end
          end
        end
        ST_CHK: begin
          if (TimeW'(rdata.arr) > sim_time) sim_time <= TimeW'(rdata.arr);
        end
        ST_RUN: begin
          if (!fin[scan_index] && TimeW'(rdata.arr) <= sim_time) begin
            if (rdata.rem <= slice_eff) begin
              sim_time <= sim_time + TimeW'(rdata.rem);
              unfinished_count <= unfinished_count - CW'(1);
            end else begin
              sim_time <= sim_time + TimeW'(slice_eff);
              if (scan_p1 >= loaded_count) scan_index <= '0;
            end
          end else if (scan_p1 >= loaded_count) begin
            scan_index <= '0;
          end
        end
        ST_NEXT: begin
          scan_index <= (TimeW'(rdata.arr) <= sim_time) ? scan_p1[IW-1:0] : '0;
        end
        ST_EMIT: begin
          if (out_free) begin
            if (unfinished_count == '0) begin
              loaded_count <= '0;
              dropped_flag <= 1'b0;
              sim_time     <= '0;
              scan_index   <= '0;
            end else if (scan_p1 >= loaded_count) begin
              scan_index <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Sort indexes, finished bits, completion math and output payload
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        si <= '0;
        tot_wait <= '0;
        tot_turn <= '0;
        if (in_xfer && in_ch.data.last_process) begin
          for (int k = 0; k < MAX_PROCESSES; k++) fin[k] <= (CW'(k) >= n_total);
        end
      end
      ST_S_LDI: begin
        cur <= rdata;
        sj  <= si_p1[IW-1:0];
      end
      ST_S_CMP: begin
        if (rdata.arr < cur.arr) cur <= rdata;
        sj <= sj_p1[IW-1:0];
      end
      ST_S_WRI: si <= si_p1[IW-1:0];
      ST_RUN: begin
        done_e <= rdata;
        if (!fin[scan_index] && TimeW'(rdata.arr) <= sim_time && rdata.rem <= slice_eff) begin
          fin[scan_index] <= 1'b1;
        end
      end
      ST_CALC: ta <= sim_time - TimeW'(done_e.arr);
      ST_WAIT: wt <= (ta >= TimeW'(done_e.bur)) ? ta - TimeW'(done_e.bur) : '0;
      ST_EMIT: begin
        if (out_free) begin
          tot_wait <= sat_add(tot_wait, wt);
          tot_turn <= sat_add(tot_turn, ta);
          out_ch.data.process_id       <= done_e.id;
          out_ch.data.finish_time      <= sim_time;
          out_ch.data.turnaround       <= ta;
          out_ch.data.waiting          <= wt;
          out_ch.data.total_waiting    <= sat_add(tot_wait, wt);
          out_ch.data.total_turnaround <= sat_add(tot_turn, ta);
          out_ch.data.overflowed       <= dropped_flag;
          out_ch.data.last_result      <= (unfinished_count == '0);
        end
      end
      default: ;
    endcase
  end

  // Finished bits, unused rows included, and the unfinished count cover the table
  a_fin_count: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |->
      ((CW'($countones(fin)) + unfinished_count) == CW'(MAX_PROCESSES)))
    else $error("finished bits disagree with unfinished count");

  // The final completion record closes the run
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_ch.valid) && out_ch.data.last_result) |-> (state == ST_IDLE))
    else $error("run still active after final record");

  // Table fill never passes its depth
  a_fill: assert property (@(posedge clk) disable iff (rst)
    loaded_count <= CW'(MAX_PROCESSES))
    else $error("table fill past depth");

  // Idle means nothing left to run
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (unfinished_count == '0))
    else $error("unfinished work while idle");

endmodule
